### rtl/core/mlr_pkg.sv
// shared types, constants and codes for the midpoint line rasterizer
`default_nettype none

package mlr_pkg;

    // coordinate width and decision width (decision terms reach about 3x a coordinate span)
    localparam int COORD_BITS = 12;
    localparam int DEC_BITS   = COORD_BITS + 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;

    // operation codes of an input item
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // slope classes: which axis is major and which way the minor axis moves
    typedef enum logic [1:0] {
        CLS_SHALLOW_UP = 2'd0,
        CLS_SHALLOW_DN = 2'd1,
        CLS_STEEP_UP   = 2'd2,
        CLS_STEEP_DN   = 2'd3
    } slope_class_t;

    // running state of the line being drawn
    typedef struct packed {
        coord_t       cur_x;
        coord_t       cur_y;
        coord_t       final_major;
        dec_t         decision;
        dec_t         step_straight;
        dec_t         step_diagonal;
        slope_class_t cls;
        logic         active;
    } line_state_t;

    // one result item
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   valid;
        logic   last;
    } pixel_t;

endpackage

`default_nettype wire

### rtl/core/mlr_setup.sv
// line setup: slope class, endpoint ordering and decision initialization
`default_nettype none

module mlr_setup (
    input  mlr_pkg::coord_t      x_start,
    input  mlr_pkg::coord_t      y_start,
    input  mlr_pkg::coord_t      x_end,
    input  mlr_pkg::coord_t      y_end,
    output mlr_pkg::line_state_t state_init,
    output logic                 first_is_last
);

    localparam int CW = mlr_pkg::COORD_BITS;
    localparam int DW = mlr_pkg::DEC_BITS;

    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic        [CW:0]   mag_dx;
    logic        [CW:0]   mag_dy;
    logic                 same_dir;
    logic                 shallow;
    logic                 swap;
    mlr_pkg::slope_class_t cls;
    logic signed [CW:0]   dx_o;
    logic signed [CW:0]   dy_o;
    mlr_pkg::dec_t        dxw;
    mlr_pkg::dec_t        dyw;
    mlr_pkg::coord_t      x0_o;
    mlr_pkg::coord_t      y0_o;
    mlr_pkg::coord_t      x1_o;
    mlr_pkg::coord_t      y1_o;

    // deltas and magnitudes, one bit wider than a coordinate
    assign dx = (CW+1)'(x_end) - (CW+1)'(x_start);
    assign dy = (CW+1)'(y_end) - (CW+1)'(y_start);
    assign mag_dx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    assign mag_dy = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
    assign same_dir = (!dy[CW]) == ((dx != '0) && !dx[CW]);
    assign shallow  = mag_dy < mag_dx;

    // slope class from integer compares
    always_comb
    begin
        if (dx == '0)
        begin
            if (dy == '0)
                cls = mlr_pkg::CLS_SHALLOW_UP;
            else if (!dy[CW])
                cls = mlr_pkg::CLS_STEEP_UP;
            else
                cls = mlr_pkg::CLS_STEEP_DN;
        end
        else if ((dy == '0) || (same_dir && shallow))
            cls = mlr_pkg::CLS_SHALLOW_UP;
        else if (shallow)
            cls = mlr_pkg::CLS_SHALLOW_DN;
        else if (same_dir)
            cls = mlr_pkg::CLS_STEEP_UP;
        else
            cls = mlr_pkg::CLS_STEEP_DN;
    end

    // order the endpoints so the major axis runs the class direction
    always_comb
    begin
        unique case (cls) inside
            mlr_pkg::CLS_SHALLOW_UP,
            mlr_pkg::CLS_SHALLOW_DN: swap = x_start > x_end;
            mlr_pkg::CLS_STEEP_UP:   swap = y_start > y_end;
            default:                 swap = y_start < y_end;
        endcase
    end

    assign x0_o = swap ? x_end   : x_start;
    assign y0_o = swap ? y_end   : y_start;
    assign x1_o = swap ? x_start : x_end;
    assign y1_o = swap ? y_start : y_end;
    assign dx_o = swap ? (CW+1)'(-dx) : dx;
    assign dy_o = swap ? (CW+1)'(-dy) : dy;
    assign dxw  = DW'(dx_o);
    assign dyw  = DW'(dy_o);

    // decision variable and its increments per class
    always_comb
    begin
        state_init.cur_x  = x0_o;
        state_init.cur_y  = y0_o;
        state_init.cls    = cls;
        unique case (cls)
            mlr_pkg::CLS_SHALLOW_UP:
            begin
                state_init.decision      = dxw - (dyw <<< 1);
                state_init.step_straight = -(dyw <<< 1);
                state_init.step_diagonal = (dxw - dyw) <<< 1;
                state_init.final_major   = x1_o;
            end
            mlr_pkg::CLS_SHALLOW_DN:
            begin
                state_init.decision      = dxw + (dyw <<< 1);
                state_init.step_straight = dyw <<< 1;
                state_init.step_diagonal = (dxw + dyw) <<< 1;
                state_init.final_major   = x1_o;
            end
            mlr_pkg::CLS_STEEP_UP:
            begin
                state_init.decision      = (dxw <<< 1) - dyw;
                state_init.step_straight = dxw <<< 1;
                state_init.step_diagonal = (dxw - dyw) <<< 1;
                state_init.final_major   = y1_o;
            end
            default:
            begin
                state_init.decision      = -dyw - (dxw <<< 1);
                state_init.step_straight = -(dxw <<< 1);
                state_init.step_diagonal = (-dyw - dxw) <<< 1;
                state_init.final_major   = y1_o;
            end
        endcase
        first_is_last = ((cls == mlr_pkg::CLS_SHALLOW_UP || cls == mlr_pkg::CLS_SHALLOW_DN)
                         ? x0_o : y0_o) == state_init.final_major;
        state_init.active = !first_is_last;
    end

endmodule

`default_nettype wire

### rtl/core/mlr_step.sv
// one midpoint step: straight or diagonal move and decision update
`default_nettype none

module mlr_step (
    input  mlr_pkg::line_state_t state_cur,
    output mlr_pkg::line_state_t state_adv,
    output logic                 adv_is_last
);

    localparam int DW = mlr_pkg::DEC_BITS;

    logic            diag;
    logic            dec_neg;
    logic            dec_zero;
    mlr_pkg::coord_t nx;
    mlr_pkg::coord_t ny;

    assign dec_neg  = state_cur.decision[DW-1];
    assign dec_zero = state_cur.decision == '0;

    // diagonal test: steep rising class tests the other sign; every class takes ties diagonally
    assign diag = (state_cur.cls == mlr_pkg::CLS_STEEP_UP) ? !dec_neg
                                                          : (dec_neg || dec_zero);

    // coordinate moves per class
    always_comb
    begin
        nx = state_cur.cur_x;
        ny = state_cur.cur_y;
        unique case (state_cur.cls)
            mlr_pkg::CLS_SHALLOW_UP:
            begin
                nx = state_cur.cur_x + 1'b1;
                if (diag)
                    ny = state_cur.cur_y + 1'b1;
            end
            mlr_pkg::CLS_SHALLOW_DN:
            begin
                nx = state_cur.cur_x + 1'b1;
                if (diag)
                    ny = state_cur.cur_y - 1'b1;
            end
            mlr_pkg::CLS_STEEP_UP:
            begin
                ny = state_cur.cur_y + 1'b1;
                if (diag)
                    nx = state_cur.cur_x + 1'b1;
            end
            default:
            begin
                ny = state_cur.cur_y - 1'b1;
                if (diag)
                    nx = state_cur.cur_x + 1'b1;
            end
        endcase
    end

    // next state and end detection on the major axis
    always_comb
    begin
        state_adv          = state_cur;
        state_adv.cur_x    = nx;
        state_adv.cur_y    = ny;
        state_adv.decision = state_cur.decision
                           + (diag ? state_cur.step_diagonal : state_cur.step_straight);
        adv_is_last = ((state_cur.cls == mlr_pkg::CLS_SHALLOW_UP
                        || state_cur.cls == mlr_pkg::CLS_SHALLOW_DN) ? nx : ny)
                      == state_cur.final_major;
        state_adv.active = !adv_is_last;
    end

endmodule

`default_nettype wire

### rtl/core/mlr_out_buf.sv
// result register with a skid stage
`default_nettype none

module mlr_out_buf (
    input  wire              clk,
    input  wire              rst_n,
    input  logic             load,
    input  mlr_pkg::pixel_t  load_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output mlr_pkg::pixel_t  out_data
);

    logic            main_valid_reg;
    logic            main_valid_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    mlr_pkg::pixel_t main_reg;
    mlr_pkg::pixel_t main_next;
    mlr_pkg::pixel_t skid_reg;
    mlr_pkg::pixel_t skid_next;
    logic            take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // fill order: main first, skid only while main waits
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = load;
                main_next       = load_data;
            end
        end
        else if (load)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = load_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = load_data;
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

### rtl/core/midpoint_line_rasterizer.sv
// top level of the midpoint line rasterizer
//
// Request channel (req_valid/req_stall) carries one item: operation plus two
// signed endpoints. A start item orders the endpoints, classifies the slope and
// returns the first pixel; each advance item returns the next pixel of the line.
// An advance with no line in progress returns an item with pixel_valid low and
// all other fields zero. The pixel that reaches the end of the major axis has
// last_pixel set, and the line is then closed.
//
// Response channel (rsp_valid/rsp_stall) carries one item per request item.
// The result is registered, in the output register or, while that one is held,
// in the skid stage. Throughput is one item per cycle while req_stall is low,
// set by the single setup/step stage before the output register. When the
// receiver stalls, a skid stage holds one more result, and req_stall rises
// only while both the output register and the skid stage are full. Reset
// (rst_n, asynchronous) empties both stages and closes any line.
`default_nettype none

module midpoint_line_rasterizer (
    input  wire                    clk,
    input  wire                    rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic                   operation,
    input  mlr_pkg::coord_t        x_start,
    input  mlr_pkg::coord_t        y_start,
    input  mlr_pkg::coord_t        x_end,
    input  mlr_pkg::coord_t        y_end,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output mlr_pkg::coord_t        pixel_x,
    output mlr_pkg::coord_t        pixel_y,
    output logic                   pixel_valid,
    output logic                   last_pixel
);

    mlr_pkg::line_state_t line_reg;
    mlr_pkg::line_state_t line_next;
    mlr_pkg::line_state_t state_init;
    mlr_pkg::line_state_t state_adv;
    mlr_pkg::pixel_t      result;
    mlr_pkg::pixel_t      out_data;
    logic                 first_is_last;
    logic                 adv_is_last;
    logic                 buf_full;
    logic                 accept;

    assign req_stall = buf_full;
    assign accept    = req_valid && !buf_full;

    mlr_setup u_setup (
        .x_start       (x_start),
        .y_start       (y_start),
        .x_end         (x_end),
        .y_end         (y_end),
        .state_init    (state_init),
        .first_is_last (first_is_last)
    );

    mlr_step u_step (
        .state_cur   (line_reg),
        .state_adv   (state_adv),
        .adv_is_last (adv_is_last)
    );

    // pick the new line state and the result for this item
    always_comb
    begin
        line_next = line_reg;
        result    = '0;
        if (operation == mlr_pkg::OP_START)
        begin
            line_next    = state_init;
            result.x     = state_init.cur_x;
            result.y     = state_init.cur_y;
            result.valid = 1'b1;
            result.last  = first_is_last;
        end
        else if (line_reg.active)
        begin
            line_next    = state_adv;
            result.x     = state_adv.cur_x;
            result.y     = state_adv.cur_y;
            result.valid = 1'b1;
            result.last  = adv_is_last;
        end
    end

    // line state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_reg <= '0;
        else if (accept)
            line_reg <= line_next;
    end

    mlr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (result),
        .full      (buf_full),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (out_data)
    );

    assign pixel_x     = out_data.x;
    assign pixel_y     = out_data.y;
    assign pixel_valid = out_data.valid;
    assign last_pixel  = out_data.last;

endmodule

`default_nettype wire

### rtl/core/mlr_checker.sv
// port-level checks for the midpoint line rasterizer
`default_nettype none

module mlr_checker (
    input wire             clk,
    input wire             rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input mlr_pkg::coord_t pixel_x,
    input mlr_pkg::coord_t pixel_y,
    input logic            pixel_valid,
    input logic            last_pixel
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(pixel_x) && $stable(pixel_y)
                                      && $stable(pixel_valid) && $stable(last_pixel)))
        else $error("stalled result changed");

    // request side only stalls while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid)
        else $error("request stalled with empty output");

    // an accepted item into an empty output shows up on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !rsp_valid) |=> rsp_valid)
        else $error("accepted item did not reach the output");

    // a no-line result is all zero and never last
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !pixel_valid) |-> (!last_pixel && pixel_x == '0 && pixel_y == '0))
        else $error("no-line result carries data");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid),
    .last_pixel  (last_pixel)
);

`default_nettype wire
